[src/pbd_pkg.sv]
// Shared types, constants and helper functions of the pulse beat detector.
package pbd_pkg;

  localparam int WINDOW_DEPTH  = 20;
  localparam int HISTORY_DEPTH = 10;

  localparam int SAMPLE_W = 10;
  localparam int DELTA_W  = 10;
  localparam int PCT_W    = 7;
  localparam int PERIOD_W = 7;
  localparam int MS_W     = 12;
  localparam int QUAL_W   = 2;
  localparam int RATE_W   = 8;

  localparam int WIN_AW  = $clog2(WINDOW_DEPTH);
  localparam int WIN_CW  = $clog2(WINDOW_DEPTH + 1);
  localparam int HIST_AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HIST_CW = $clog2(HISTORY_DEPTH + 1);

  localparam int MS_MAX           = (1 << MS_W) - 1;
  localparam int SAMPLE_MAX       = (1 << SAMPLE_W) - 1;
  localparam int SUM_W            = $clog2(HISTORY_DEPTH * MS_MAX + 1);
  localparam int SINCE_W          = MS_W + 1;
  localparam int REFR_W           = MS_W + 4;
  localparam int REFR_MUL_SINCE   = 5;
  localparam int REFR_MUL_LAST    = 3;
  localparam int TIMEOUT_INTERVAL = 750;
  localparam int MS_PER_MINUTE    = 60000;
  localparam int RATE_NUM_INT     = MS_PER_MINUTE * HISTORY_DEPTH;
  localparam int NUM_W            = $clog2(RATE_NUM_INT + 1);
  localparam logic [NUM_W-1:0] RATE_NUM = NUM_W'(RATE_NUM_INT);

  // Division by 100 as a multiplication by a scaled reciprocal; exact for
  // every product of a 10-bit amplitude and a 7-bit percent value.
  localparam int PROD_W      = SAMPLE_W + PCT_W;
  localparam int RECIP_W     = 18;
  localparam int RECIP_SHIFT = 24;
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(167773);
  localparam int QUO_W       = PROD_W + RECIP_W - RECIP_SHIFT;

  localparam int QUAL_OK_MAX   = 1;
  localparam int QUAL_WEAK_MAX = 5;

  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (QUAL_W + 1 + 1 + RATE_W + 1);

  localparam logic [SAMPLE_W-1:0] BASE_LEVEL_RST  = SAMPLE_W'(510);
  localparam logic [DELTA_W-1:0]  MAX_DELTA_RST   = DELTA_W'(30);
  localparam logic [PCT_W-1:0]    AMP_PCT_RST     = PCT_W'(65);
  localparam logic [PERIOD_W-1:0] PERIOD_RST      = PERIOD_W'(10);
  localparam logic [MS_W-1:0]     MIN_INTERVAL_RST = MS_W'(400);
  localparam logic [MS_W-1:0]     TIMEOUT_RST     = MS_W'(2000);

  typedef enum logic [QUAL_W-1:0] {
    QUAL_OK   = 2'd0,
    QUAL_WEAK = 2'd1,
    QUAL_BAD  = 2'd2
  } quality_e;

  typedef enum logic [2:0] {
    REG_BASE_LEVEL   = 3'd0,
    REG_MAX_DELTA    = 3'd1,
    REG_AMP_PCT      = 3'd2,
    REG_PERIOD       = 3'd3,
    REG_MIN_INTERVAL = 3'd4,
    REG_TIMEOUT      = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PROC,
    ST_RECALC,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] thr;
    logic [SAMPLE_W-1:0] floor_lvl;
    logic [SAMPLE_W-1:0] peak_lvl;
  } levels_t;

  typedef struct packed {
    logic     done;
    logic     graded;
    quality_e quality;
  } grade_t;

  function automatic logic [SAMPLE_W-1:0] absdiff(input logic [SAMPLE_W-1:0] a,
                                                  input logic [SAMPLE_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

[src/pbd_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module pbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/pbd_grader.sv]
// Sample window memory and the scan that grades signal quality.
module pbd_grader (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [pbd_pkg::SAMPLE_W-1:0]   sample_i,
  input  pbd_pkg::levels_t               levels_i,
  input  logic [pbd_pkg::SAMPLE_W-1:0]   base_level_i,
  input  logic [pbd_pkg::DELTA_W-1:0]    max_delta_i,
  output pbd_pkg::grade_t                grade_o
);

  localparam int DEPTH = pbd_pkg::WINDOW_DEPTH;
  localparam int AW    = pbd_pkg::WIN_AW;
  localparam int CW    = pbd_pkg::WIN_CW;

  logic [AW-1:0] wptr_q, wptr_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [AW-1:0] raddr_q, raddr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          scan_q, scan_d;
  logic          pend_q, pend_d;
  logic          last_q, last_d;
  logic          skip_q, skip_d;

  logic [pbd_pkg::SAMPLE_W-1:0] rdata;
  logic [pbd_pkg::SAMPLE_W-1:0] ref_lvl;
  logic                         hit;
  logic [CW-1:0]                cnt_sum;
  logic                         full_next;

  pbd_ram #(
    .WIDTH(pbd_pkg::SAMPLE_W),
    .DEPTH(DEPTH)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (start_i),
    .waddr_i(wptr_q),
    .wdata_i(sample_i),
    .raddr_i(raddr_q),
    .rdata_o(rdata)
  );

  always_comb begin
    ref_lvl = (pbd_pkg::absdiff(levels_i.thr, base_level_i) < max_delta_i) ?
              levels_i.thr : base_level_i;
    hit = (pbd_pkg::absdiff(rdata, ref_lvl) >= max_delta_i) &&
          ((rdata < levels_i.floor_lvl) || (rdata > levels_i.peak_lvl));
    cnt_sum = cnt_q + ((pend_q && hit) ? CW'(1) : CW'(0));
    full_next = (fill_q >= CW'(DEPTH - 1));
  end

  always_comb begin
    wptr_d  = wptr_q;
    fill_d  = fill_q;
    raddr_d = raddr_q;
    cnt_d   = cnt_sum;
    scan_d  = scan_q;
    pend_d  = scan_q;
    last_d  = scan_q && (raddr_q == AW'(DEPTH - 1));
    skip_d  = 1'b0;
    if (scan_q) begin
      raddr_d = (raddr_q == AW'(DEPTH - 1)) ? '0 : raddr_q + AW'(1);
      if (raddr_q == AW'(DEPTH - 1)) begin
        scan_d = 1'b0;
      end
    end
    if (start_i) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
      fill_d = (fill_q == CW'(DEPTH)) ? fill_q : fill_q + CW'(1);
      cnt_d  = '0;
      if (full_next) begin
        scan_d  = 1'b1;
        raddr_d = '0;
      end else begin
        skip_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      fill_q  <= '0;
      raddr_q <= '0;
      cnt_q   <= '0;
      scan_q  <= 1'b0;
      pend_q  <= 1'b0;
      last_q  <= 1'b0;
      skip_q  <= 1'b0;
    end else begin
      wptr_q  <= wptr_d;
      fill_q  <= fill_d;
      raddr_q <= raddr_d;
      cnt_q   <= cnt_d;
      scan_q  <= scan_d;
      pend_q  <= pend_d;
      last_q  <= last_d;
      skip_q  <= skip_d;
    end
  end

  always_comb begin
    grade_o.done   = skip_q || last_q;
    grade_o.graded = last_q;
    priority if (cnt_sum <= CW'(pbd_pkg::QUAL_OK_MAX)) begin
      grade_o.quality = pbd_pkg::QUAL_OK;
    end else if (cnt_sum <= CW'(pbd_pkg::QUAL_WEAK_MAX)) begin
      grade_o.quality = pbd_pkg::QUAL_WEAK;
    end else begin
      grade_o.quality = pbd_pkg::QUAL_BAD;
    end
  end

endmodule

[src/pbd_rate_div.sv]
// Iterative divider that turns the interval sum into a saturated beat rate.
module pbd_rate_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pbd_pkg::SUM_W-1:0]    sum_i,
  output logic                         done_o,
  output logic [pbd_pkg::RATE_W-1:0]   rate_o
);

  localparam int SW = pbd_pkg::SUM_W;
  localparam int RW = pbd_pkg::RATE_W;
  localparam int IW = $clog2(RW);
  localparam logic [SW-1:0] REM_INIT = SW'(pbd_pkg::RATE_NUM >> RW);
  localparam logic [RW-1:0] NUM_LOW  = pbd_pkg::RATE_NUM[RW-1:0];

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [SW-1:0] rem_q, rem_d;
  logic [SW-1:0] div_q, div_d;
  logic [RW-1:0] quo_q, quo_d;

  logic          sat;
  logic [SW:0]   rem_sh;
  logic          ge;

  always_comb begin
    sat    = {sum_i, RW'(0)} <= (SW + RW)'(pbd_pkg::RATE_NUM);
    rem_sh = {rem_q, NUM_LOW[idx_q]};
    ge     = rem_sh >= {1'b0, div_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    idx_d  = idx_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (start_i) begin
      if (sat) begin
        quo_d  = '1;
        done_d = 1'b1;
      end else begin
        rem_d  = REM_INIT;
        div_d  = sum_i;
        idx_d  = IW'(RW - 1);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      quo_d = {quo_q[RW-2:0], ge};
      rem_d = ge ? SW'(rem_sh - {1'b0, div_q}) : SW'(rem_sh);
      if (idx_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        idx_d = idx_q - IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign rate_o = quo_q;

endmodule

[src/pulse_beat_detector.sv]
// Pulse beat detector top level: control, level tracking and beat history.
// Use: one 10-bit pulse-sensor word enters on the s_axis channel per sample;
// for every accepted word exactly one result word leaves on m_axis, in order.
// Registers are to be written over the APB port only while no word is in
// flight; the block itself does not enforce this. An accepted word is
// graded in the scan state; before the sample window has filled, the scan
// is skipped. Once the window is full, every word scans the whole window
// memory, one entry per cycle. An ok grade leads through the proc and
// recalc states to fin, any other grade goes straight to fin. A beat that
// leaves the interval history full runs the rate divider in the divide
// state, one quotient bit per cycle.
// The next word is accepted only after the result of the previous one has
// moved into the output register; a stalled receiver holds that register,
// and the block takes one more word and then waits with its result.
// Reset clears the window fill count, the tracking levels (to the reset
// base level), timing state, the history fill count and the rate. No
// memory clearing pass is needed.
module pulse_beat_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [pbd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [9:0] sample
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [1:0] quality, [2] beat, [3] rate_valid, [11:4] beats_per_minute, [12] in_pulse
  output logic [pbd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pbd_pkg::ADDR_W-1:0]          paddr,
  input  logic [pbd_pkg::DATA_W-1:0]          pwdata,
  output logic [pbd_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  localparam int SW  = pbd_pkg::SAMPLE_W;
  localparam int MW  = pbd_pkg::MS_W;
  localparam int HD  = pbd_pkg::HISTORY_DEPTH;
  localparam int HAW = pbd_pkg::HIST_AW;
  localparam int HCW = pbd_pkg::HIST_CW;
  localparam int UW  = pbd_pkg::SUM_W;
  localparam int NW  = pbd_pkg::SINCE_W;
  localparam int FW  = pbd_pkg::REFR_W;
  localparam int PW  = pbd_pkg::PROD_W;
  localparam int QW  = pbd_pkg::QUO_W;

  logic [SW-1:0]                base_q, base_d;
  logic [pbd_pkg::DELTA_W-1:0]  delta_q, delta_d;
  logic [pbd_pkg::PCT_W-1:0]    pct_q, pct_d;
  logic [pbd_pkg::PERIOD_W-1:0] period_q, period_d;
  logic [MW-1:0]                min_iv_q, min_iv_d;
  logic [MW-1:0]                tmo_q, tmo_d;

  pbd_pkg::state_e   state_q, state_d;
  pbd_pkg::quality_e quality_q, quality_d;
  logic [SW-1:0]     thr_q, thr_d;
  logic [SW-1:0]     floor_q, floor_d;
  logic [SW-1:0]     peak_q, peak_d;
  logic [MW-1:0]     elapsed_q, elapsed_d;
  logic [MW-1:0]     last_q, last_d;
  logic              pulse_q, pulse_d;
  logic [HAW-1:0]    hptr_q, hptr_d;
  logic [HCW-1:0]    hfill_q, hfill_d;
  logic [UW-1:0]     sum_q, sum_d;
  logic [pbd_pkg::RATE_W-1:0] rate_q, rate_d;
  logic              m_tvalid_q, m_tvalid_d;

  logic [SW-1:0]     sample_q, sample_d;
  logic              beat_q, beat_d;
  logic              recalc_q, recalc_d;
  logic              divgo_q, divgo_d;
  logic [PW-1:0]     prod_q, prod_d;
  logic [pbd_pkg::OUT_TDATA_W-1:0] m_tdata_q, m_tdata_d;

  logic accept, grade_start, div_start, out_load, cfg_wr;

  pbd_pkg::levels_t levels;
  pbd_pkg::grade_t  grade;
  logic             div_done;
  logic [pbd_pkg::RATE_W-1:0] div_rate;

  logic [MW-1:0] oldest_raw, oldest;
  logic          hist_we;

  logic [NW-1:0] since;
  logic          refr_over, s_lt_thr, s_gt_thr, beat, fall, tmo;
  logic [SW-1:0] floor_n, peak_n, amp;
  logic [MW-1:0] iv;
  logic [PW+pbd_pkg::RECIP_W-1:0] recip_prod;
  logic [QW:0]   cand_raw;
  logic [SW-1:0] cand, thr_new;
  logic          rate_valid;

  assign levels.thr       = thr_q;
  assign levels.floor_lvl = floor_q;
  assign levels.peak_lvl  = peak_q;

  pbd_grader u_grader (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (grade_start),
    .sample_i    (s_axis_tdata[SW-1:0]),
    .levels_i    (levels),
    .base_level_i(base_q),
    .max_delta_i (delta_q),
    .grade_o     (grade)
  );

  pbd_ram #(
    .WIDTH(MW),
    .DEPTH(HD)
  ) u_history (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(hptr_q),
    .wdata_i(iv),
    .raddr_i(hptr_q),
    .rdata_o(oldest_raw)
  );

  pbd_rate_div u_rate_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .sum_i  (sum_q),
    .done_o (div_done),
    .rate_o (div_rate)
  );

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    base_d   = base_q;
    delta_d  = delta_q;
    pct_d    = pct_q;
    period_d = period_q;
    min_iv_d = min_iv_q;
    tmo_d    = tmo_q;
    if (cfg_wr) begin
      unique case (paddr[4:2])
        pbd_pkg::REG_BASE_LEVEL:   base_d   = pwdata[SW-1:0];
        pbd_pkg::REG_MAX_DELTA:    delta_d  = pwdata[pbd_pkg::DELTA_W-1:0];
        pbd_pkg::REG_AMP_PCT:      pct_d    = pwdata[pbd_pkg::PCT_W-1:0];
        pbd_pkg::REG_PERIOD:       period_d = pwdata[pbd_pkg::PERIOD_W-1:0];
        pbd_pkg::REG_MIN_INTERVAL: min_iv_d = pwdata[MW-1:0];
        pbd_pkg::REG_TIMEOUT:      tmo_d    = pwdata[MW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      pbd_pkg::REG_BASE_LEVEL:   prdata = pbd_pkg::DATA_W'(base_q);
      pbd_pkg::REG_MAX_DELTA:    prdata = pbd_pkg::DATA_W'(delta_q);
      pbd_pkg::REG_AMP_PCT:      prdata = pbd_pkg::DATA_W'(pct_q);
      pbd_pkg::REG_PERIOD:       prdata = pbd_pkg::DATA_W'(period_q);
      pbd_pkg::REG_MIN_INTERVAL: prdata = pbd_pkg::DATA_W'(min_iv_q);
      pbd_pkg::REG_TIMEOUT:      prdata = pbd_pkg::DATA_W'(tmo_q);
      default:                   prdata = '0;
    endcase
  end

  // Per-sample tracking, evaluated from the state held before this sample.
  always_comb begin
    since     = NW'(elapsed_q) + NW'(period_q);
    refr_over = (FW'(since) * FW'(pbd_pkg::REFR_MUL_SINCE)) >
                (FW'(last_q) * FW'(pbd_pkg::REFR_MUL_LAST));
    s_lt_thr  = sample_q < thr_q;
    s_gt_thr  = sample_q > thr_q;
    floor_n   = (s_lt_thr && refr_over && (sample_q < floor_q)) ? sample_q : floor_q;
    peak_n    = (s_gt_thr && (sample_q > peak_q)) ? sample_q : peak_q;
    beat      = (since > NW'(min_iv_q)) && s_gt_thr && !pulse_q && refr_over;
    iv        = (since > NW'(pbd_pkg::MS_MAX)) ? MW'(pbd_pkg::MS_MAX) : since[MW-1:0];
    fall      = s_lt_thr && pulse_q;
    tmo       = since > NW'(tmo_q);
    amp       = (peak_n > floor_n) ? (peak_n - floor_n) : '0;
    oldest    = (hfill_q == HCW'(HD)) ? oldest_raw : '0;
    hist_we   = (state_q == pbd_pkg::ST_PROC) && beat;
  end

  // Threshold recalculation from the registered amplitude product.
  always_comb begin
    recip_prod = (PW + pbd_pkg::RECIP_W)'(prod_q) *
                 (PW + pbd_pkg::RECIP_W)'(pbd_pkg::RECIP_100);
    cand_raw   = (QW + 1)'(floor_q) +
                 (QW + 1)'(recip_prod[pbd_pkg::RECIP_SHIFT +: QW]);
    cand       = (cand_raw > (QW + 1)'(pbd_pkg::SAMPLE_MAX)) ?
                 SW'(pbd_pkg::SAMPLE_MAX) : cand_raw[SW-1:0];
    thr_new    = (pbd_pkg::absdiff(cand, thr_q) <= delta_q) ? cand : thr_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pbd_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = pbd_pkg::ST_SCAN;
        end
      end
      pbd_pkg::ST_SCAN: begin
        if (grade.done) begin
          state_d = (quality_d == pbd_pkg::QUAL_OK) ? pbd_pkg::ST_PROC : pbd_pkg::ST_FIN;
        end
      end
      pbd_pkg::ST_PROC: begin
        state_d = pbd_pkg::ST_RECALC;
      end
      pbd_pkg::ST_RECALC: begin
        state_d = divgo_q ? pbd_pkg::ST_DIV : pbd_pkg::ST_FIN;
      end
      pbd_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = pbd_pkg::ST_FIN;
        end
      end
      pbd_pkg::ST_FIN: begin
        if (out_load) begin
          state_d = pbd_pkg::ST_IDLE;
        end
      end
      default: state_d = pbd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = state_q == pbd_pkg::ST_IDLE;
    accept        = s_axis_tvalid && s_axis_tready;
    grade_start   = accept;
    div_start     = (state_q == pbd_pkg::ST_RECALC) && divgo_q;
    out_load      = (state_q == pbd_pkg::ST_FIN) && (!m_tvalid_q || m_axis_tready);
  end

  always_comb begin
    quality_d = quality_q;
    thr_d     = thr_q;
    floor_d   = floor_q;
    peak_d    = peak_q;
    elapsed_d = elapsed_q;
    last_d    = last_q;
    pulse_d   = pulse_q;
    hptr_d    = hptr_q;
    hfill_d   = hfill_q;
    sum_d     = sum_q;
    rate_d    = rate_q;
    sample_d  = sample_q;
    beat_d    = beat_q;
    recalc_d  = recalc_q;
    divgo_d   = divgo_q;
    prod_d    = prod_q;

    if (accept) begin
      sample_d = s_axis_tdata[SW-1:0];
      beat_d   = 1'b0;
      recalc_d = 1'b0;
      divgo_d  = 1'b0;
    end
    if (grade.done && grade.graded) begin
      quality_d = grade.quality;
    end
    if (state_q == pbd_pkg::ST_PROC) begin
      floor_d   = floor_n;
      peak_d    = peak_n;
      beat_d    = beat;
      pulse_d   = (pulse_q || beat) && !fall && !tmo;
      elapsed_d = (beat || tmo) ? '0 : since[MW-1:0];
      last_d    = tmo ? MW'(pbd_pkg::TIMEOUT_INTERVAL) : (beat ? iv : last_q);
      recalc_d  = fall || tmo;
      prod_d    = PW'(amp) * PW'(pct_q);
      if (beat) begin
        hptr_d  = (hptr_q == HAW'(HD - 1)) ? '0 : hptr_q + HAW'(1);
        hfill_d = (hfill_q == HCW'(HD)) ? hfill_q : hfill_q + HCW'(1);
        sum_d   = sum_q - UW'(oldest) + UW'(iv);
        divgo_d = hfill_q >= HCW'(HD - 1);
      end
    end
    if ((state_q == pbd_pkg::ST_RECALC) && recalc_q) begin
      thr_d   = thr_new;
      floor_d = thr_new;
      peak_d  = thr_new;
    end
    if (div_done) begin
      rate_d = div_rate;
    end
  end

  always_comb begin
    rate_valid = hfill_q == HCW'(HD);
    m_tvalid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_tvalid_q);
    m_tdata_d  = m_tdata_q;
    if (out_load) begin
      m_tdata_d = {{pbd_pkg::OUT_PAD_W{1'b0}}, pulse_q,
                   (rate_valid ? rate_q : '0), rate_valid, beat_q, quality_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= pbd_pkg::BASE_LEVEL_RST;
      delta_q    <= pbd_pkg::MAX_DELTA_RST;
      pct_q      <= pbd_pkg::AMP_PCT_RST;
      period_q   <= pbd_pkg::PERIOD_RST;
      min_iv_q   <= pbd_pkg::MIN_INTERVAL_RST;
      tmo_q      <= pbd_pkg::TIMEOUT_RST;
      state_q    <= pbd_pkg::ST_IDLE;
      quality_q  <= pbd_pkg::QUAL_OK;
      thr_q      <= pbd_pkg::BASE_LEVEL_RST;
      floor_q    <= pbd_pkg::BASE_LEVEL_RST;
      peak_q     <= pbd_pkg::BASE_LEVEL_RST;
      elapsed_q  <= '0;
      last_q     <= '0;
      pulse_q    <= 1'b0;
      hptr_q     <= '0;
      hfill_q    <= '0;
      sum_q      <= '0;
      rate_q     <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      base_q     <= base_d;
      delta_q    <= delta_d;
      pct_q      <= pct_d;
      period_q   <= period_d;
      min_iv_q   <= min_iv_d;
      tmo_q      <= tmo_d;
      state_q    <= state_d;
      quality_q  <= quality_d;
      thr_q      <= thr_d;
      floor_q    <= floor_d;
      peak_q     <= peak_d;
      elapsed_q  <= elapsed_d;
      last_q     <= last_d;
      pulse_q    <= pulse_d;
      hptr_q     <= hptr_d;
      hfill_q    <= hfill_d;
      sum_q      <= sum_d;
      rate_q     <= rate_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q  <= sample_d;
    beat_q    <= beat_d;
    recalc_q  <= recalc_d;
    divgo_q   <= divgo_d;
    prod_q    <= prod_d;
    m_tdata_q <= m_tdata_d;
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

`ifndef SYNTHESIS
  a_grade_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grade.done |-> (state_q == pbd_pkg::ST_SCAN))
    else $error("Window grading finished outside the scan state.");

  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == pbd_pkg::ST_DIV))
    else $error("Rate divider finished outside the divide state.");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == pbd_pkg::ST_SCAN))
    else $error("Accepted word did not start a window scan.");
`endif

endmodule

[tb/tb_pulse_beat_detector.sv]
// Self-checking testbench of the pulse beat detector with a built-in behavioral predictor.
`timescale 1ns / 100ps

module tb_pulse_beat_detector;
  import pbd_pkg::*;

  localparam int DIR_ROWS        = 25;
  localparam int FIXED_PHASES    = 5;
  localparam int NUM_PHASES      = 9;
  localparam int QUIET_PHASE     = 4;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int IDLE_PCT        = 27;
  localparam int JITTER          = 12;
  localparam int DRAIN_CYCLES    = WINDOW_DEPTH + 20;
  localparam int STALL_LIMIT     = 2000;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [SAMPLE_W-1:0]    smp;
    bit                     typed;
    logic [OUT_TDATA_W-1:0] report;
  } stim_row_t;

  typedef struct packed {
    int base;
    int delta;
    int pct;
    int period;
    int min_iv;
    int tmo;
    int mid;
    int amp;
    int len;
    int hi;
    int noise;
  } phase_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [9:0] sample
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [1:0] quality, [2] beat, [3] rate_valid, [11:4] beats_per_minute, [12] in_pulse
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_W-1:0]      paddr = '0;
  logic [DATA_W-1:0]      pwdata = '0;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;

  pulse_beat_detector u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk_i = ~clk_i;

  // Until the window fills, no beat is possible with the reset timing, so every
  // word reports all zeros; the last rows are graded and checked by prediction.
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{10'd0,    1'b1, 16'h0000}, '{10'd1023, 1'b1, 16'h0000}, '{10'd341,  1'b1, 16'h0000},
    '{10'd682,  1'b1, 16'h0000}, '{10'd510,  1'b1, 16'h0000}, '{10'd511,  1'b1, 16'h0000},
    '{10'd509,  1'b1, 16'h0000}, '{10'd1,    1'b1, 16'h0000}, '{10'd1022, 1'b1, 16'h0000},
    '{10'd512,  1'b1, 16'h0000}, '{10'd255,  1'b1, 16'h0000}, '{10'd768,  1'b1, 16'h0000},
    '{10'd0,    1'b1, 16'h0000}, '{10'd1023, 1'b1, 16'h0000}, '{10'd100,  1'b1, 16'h0000},
    '{10'd900,  1'b1, 16'h0000}, '{10'd510,  1'b1, 16'h0000}, '{10'd510,  1'b1, 16'h0000},
    '{10'd510,  1'b1, 16'h0000}, '{10'd1023, 1'b0, 16'h0000}, '{10'd0,    1'b0, 16'h0000},
    '{10'd1023, 1'b0, 16'h0000}, '{10'd0,    1'b0, 16'h0000}, '{10'd510,  1'b0, 16'h0000},
    '{10'd1023, 1'b0, 16'h0000}
  };

  phase_t fixed_phases [FIXED_PHASES] = '{
    '{510,  300,  65,  50,  400,  2000, 510, 200, 16, 3, 0},
    '{200,  1023, 100, 100, 0,    4095, 200, 150, 41, 1, 0},
    '{1023, 0,    0,   1,   4095, 0,    800, 100, 10, 3, 20},
    '{0,    100,  127, 20,  60,   3000, 300, 100, 5,  1, 0},
    '{700,  300,  65,  50,  400,  2000, 510, 200, 16, 3, 5}
  };

  int cfg_base, cfg_delta, cfg_pct, cfg_period, cfg_min, cfg_timeout;
  int win [WINDOW_DEPTH];
  int win_fill;
  quality_e qual;
  int thr, flr, pk;
  int elapsed, last_iv;
  bit pulse;
  int hist [HISTORY_DEPTH];
  int rate;

  logic [OUT_TDATA_W-1:0] pending_reports [$];
  int     mismatch_count = 0;
  int     stall_cycles = 0;
  bit     idle_on = 1'b1;
  phase_t wave;

  function automatic int level_gap(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void reset_model();
    cfg_base    = int'(BASE_LEVEL_RST);
    cfg_delta   = int'(MAX_DELTA_RST);
    cfg_pct     = int'(AMP_PCT_RST);
    cfg_period  = int'(PERIOD_RST);
    cfg_min     = int'(MIN_INTERVAL_RST);
    cfg_timeout = int'(TIMEOUT_RST);
    foreach (win[i]) win[i] = 0;
    foreach (hist[i]) hist[i] = 0;
    win_fill = 0;
    qual     = QUAL_OK;
    thr      = cfg_base;
    flr      = cfg_base;
    pk       = cfg_base;
    elapsed  = 0;
    last_iv  = 0;
    pulse    = 1'b0;
    rate     = 0;
  endfunction

  function automatic void grade_signal();
    int ref_lvl;
    int hits;
    ref_lvl = (level_gap(thr, cfg_base) < cfg_delta) ? thr : cfg_base;
    hits = 0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      if (level_gap(win[i], ref_lvl) >= cfg_delta && (win[i] < flr || win[i] > pk)) begin
        hits++;
      end
    end
    qual = (hits <= QUAL_OK_MAX) ? QUAL_OK : ((hits <= QUAL_WEAK_MAX) ? QUAL_WEAK : QUAL_BAD);
  endfunction

  function automatic void retune_threshold();
    int amp;
    int cand;
    amp = pk - flr;
    if (amp < 0) amp = 0;
    cand = flr + (amp * cfg_pct) / 100;
    if (cand > SAMPLE_MAX) cand = SAMPLE_MAX;
    if (level_gap(cand, thr) <= cfg_delta) thr = cand;
    flr = thr;
    pk  = thr;
  endfunction

  function automatic bit track_sample(int s);
    int since;
    int iv;
    int total;
    bit refr_over;
    bit hit;
    since     = elapsed + cfg_period;
    refr_over = REFR_MUL_SINCE * since > REFR_MUL_LAST * last_iv;
    hit       = 1'b0;
    elapsed   = since;
    if (s < thr && refr_over && s < flr) flr = s;
    if (s > thr && s > pk) pk = s;
    if (since > cfg_min && s > thr && !pulse && refr_over) begin
      iv      = (since > MS_MAX) ? MS_MAX : since;
      hit     = 1'b1;
      pulse   = 1'b1;
      last_iv = iv;
      elapsed = 0;
      total   = 0;
      for (int i = 0; i + 1 < HISTORY_DEPTH; i++) begin
        hist[i] = hist[i + 1];
        total += hist[i];
      end
      hist[HISTORY_DEPTH - 1] = iv;
      total += iv;
      if (hist[0] != 0 && total != 0) begin
        rate = (MS_PER_MINUTE * HISTORY_DEPTH) / total;
        if (rate > 255) rate = 255;
      end
    end
    if (s < thr && pulse) begin
      pulse = 1'b0;
      retune_threshold();
    end
    if (since > cfg_timeout) begin
      last_iv = TIMEOUT_INTERVAL;
      pulse   = 1'b0;
      elapsed = 0;
      retune_threshold();
    end
    return hit;
  endfunction

  function automatic logic [OUT_TDATA_W-1:0] next_beat_report(int s);
    bit hit;
    bit valid;
    for (int i = 0; i + 1 < WINDOW_DEPTH; i++) win[i] = win[i + 1];
    win[WINDOW_DEPTH - 1] = s;
    if (win_fill < WINDOW_DEPTH) win_fill++;
    if (win_fill >= WINDOW_DEPTH) grade_signal();
    hit = 1'b0;
    if (qual == QUAL_OK) hit = track_sample(s);
    valid = hist[0] != 0;
    return {OUT_PAD_W'(0), pulse, valid ? 8'(rate) : 8'h00, valid, hit, qual};
  endfunction

  function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch on %s: expected %h, got %h", what, want, got);
    end
  endfunction

  function automatic int wave_sample(int k);
    int v;
    if (int'($urandom_range(99)) < wave.noise) return int'($urandom_range(SAMPLE_MAX));
    v = ((k % wave.len) < wave.hi) ? wave.mid + wave.amp : wave.mid - wave.amp / 2;
    v = v + int'($urandom_range(2 * JITTER)) - JITTER;
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v;
  endfunction

  function automatic phase_t random_phase();
    phase_t ph;
    ph.base   = int'($urandom_range(SAMPLE_MAX));
    ph.delta  = int'($urandom_range(20, 400));
    ph.pct    = int'($urandom_range(100));
    ph.period = int'($urandom_range(1, 100));
    ph.min_iv = int'($urandom_range(1200));
    ph.tmo    = int'($urandom_range(MS_MAX));
    ph.mid    = (ph.base < 150) ? 150 : ((ph.base > 870) ? 870 : ph.base);
    ph.amp    = int'($urandom_range(150));
    ph.len    = int'($urandom_range(3, 30));
    ph.hi     = int'($urandom_range(1, ph.len / 3 + 1));
    ph.noise  = int'($urandom_range(15));
    return ph;
  endfunction

  task automatic write_reg(reg_idx_e idx, int value);
    logic [DATA_W-1:0] word;
    logic [DATA_W-1:0] back;
    case (idx)
      REG_BASE_LEVEL: begin
        word = value & SAMPLE_MAX;
        cfg_base = int'(word);
      end
      REG_MAX_DELTA: begin
        word = value & ((1 << DELTA_W) - 1);
        cfg_delta = int'(word);
      end
      REG_AMP_PCT: begin
        word = value & ((1 << PCT_W) - 1);
        cfg_pct = int'(word);
      end
      REG_PERIOD: begin
        word = value & ((1 << PERIOD_W) - 1);
        cfg_period = int'(word);
      end
      REG_MIN_INTERVAL: begin
        word = value & MS_MAX;
        cfg_min = int'(word);
      end
      default: begin
        word = value & MS_MAX;
        cfg_timeout = int'(word);
      end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    back = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (back !== word) note_mismatch("register readback", word, back);
  endtask

  task automatic push_sample(int smp, bit typed, logic [OUT_TDATA_W-1:0] typed_report);
    logic [OUT_TDATA_W-1:0] predicted;
    while (idle_on && int'($urandom_range(99)) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(smp);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = next_beat_report(smp);
    pending_reports.push_back(typed ? typed_report : predicted);
  endtask

  always @(posedge clk_i) begin
    logic [OUT_TDATA_W-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_reports.size() == 0) begin
        note_mismatch("unexpected word", '0, m_axis_tdata);
      end else begin
        want = pending_reports.pop_front();
        if (want[1:0] !== m_axis_tdata[1:0]) note_mismatch("quality", want[1:0], m_axis_tdata[1:0]);
        if (want[2] !== m_axis_tdata[2]) note_mismatch("beat", want[2], m_axis_tdata[2]);
        if (want[3] !== m_axis_tdata[3]) note_mismatch("rate_valid", want[3], m_axis_tdata[3]);
        if (want[11:4] !== m_axis_tdata[11:4]) begin
          note_mismatch("beats_per_minute", want[11:4], m_axis_tdata[11:4]);
        end
        if (want[12] !== m_axis_tdata[12]) note_mismatch("in_pulse", want[12], m_axis_tdata[12]);
      end
    end
    m_axis_tready <= !idle_on || (int'($urandom_range(99)) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    phase_t ph;
    reset_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) begin
      push_sample(int'(dir_rows[r].smp), dir_rows[r].typed, dir_rows[r].report);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      ph = (p < FIXED_PHASES) ? fixed_phases[p] : random_phase();
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while (pending_reports.size() != 0) @(posedge clk_i);
      write_reg(REG_BASE_LEVEL, ph.base);
      write_reg(REG_MAX_DELTA, ph.delta);
      write_reg(REG_AMP_PCT, ph.pct);
      write_reg(REG_PERIOD, ph.period);
      write_reg(REG_MIN_INTERVAL, ph.min_iv);
      write_reg(REG_TIMEOUT, ph.tmo);
      wave    = ph;
      idle_on = (p != QUIET_PHASE);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) push_sample(wave_sample(k), 1'b0, '0);
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
